// ===== hdl/dotq_pkg.sv =====
// Shared types, codes and a helper function for the deadline-ordered timer queue.
package dotq_pkg;

   // Command codes carried in the request tuser bit
   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_FIRED    = 2'd2;
   localparam logic [1:0] ST_IDLE     = 2'd3;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned JOB_W   = 8;
   localparam int unsigned COUNT_W = 5;

   // One stored queue entry
   typedef struct packed {
      logic [JOB_W-1:0]  job;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   // One request transaction
   typedef struct packed {
      logic              cmd;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] delay_ticks;
      logic [JOB_W-1:0]  job_id;
   } req_type;

   // One response transaction
   typedef struct packed {
      logic [1:0]         status;
      logic [JOB_W-1:0]   fired_id;
      logic               match_valid;
      logic [TIME_W-1:0]  match_deadline;
      logic [COUNT_W-1:0] pending_count;
   } rsp_type;

   // Ordering key: deadlines already behind the current time count one period later
   function automatic logic [TIME_W:0] sort_key(input logic [TIME_W-1:0] deadline,
                                                input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] period);
      logic [TIME_W:0] key;
      if (deadline < now) begin
         key = {1'b0, deadline} + {1'b0, period};
      end else begin
         key = {1'b0, deadline};
      end
      return key;
   endfunction

endpackage

// ===== hdl/dotq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dotq_ram #(
   parameter int unsigned WIDTH = 40,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dotq_ctrl.sv =====
// Sequencer for the timer queue: schedule, stable re-sort in RAM, and pop on tick.
module dotq_ctrl
   import dotq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [TIME_W-1:0]              period,
   input  logic                           req_valid,
   input  req_type                        req,
   output logic                           req_ready,
   output logic                           res_valid,
   output rsp_type                        res,
   input  logic                           res_take,
   output logic                           ram_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] ram_wr_addr,
   output entry_type                      ram_wr_data,
   output logic [$clog2(QUEUE_DEPTH)-1:0] ram_rd_addr,
   input  entry_type                      ram_rd_data
);

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CALC  = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_FETCH = 4'd3;
   localparam logic [3:0] S_CMP   = 4'd4;
   localparam logic [3:0] S_PLACE = 4'd5;
   localparam logic [3:0] S_HRD   = 4'd6;
   localparam logic [3:0] S_HLD   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     i_ff, i_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [JOB_W-1:0]  job_ff, job_in;
   logic [TIME_W:0]   sum_ff, sum_in;
   entry_type         cur_ff, cur_in;
   logic [TIME_W:0]   cur_key_ff, cur_key_in;
   logic [TIME_W-1:0] head_dl_ff, head_dl_in;
   logic [JOB_W-1:0]  head_job_ff, head_job_in;
   logic [1:0]        status_ff, status_in;
   logic [JOB_W-1:0]  fired_ff, fired_in;

   logic [TIME_W:0]   new_dl;
   logic [TIME_W:0]   rd_key;
   logic              more_items;
   logic [AW-1:0]     head_next;

   // Map a queue position onto a RAM address relative to the head
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] pos);
      logic [AW:0] s;
      s = {1'b0, head} + {1'b0, pos};
      if (s >= (AW+1)'(QUEUE_DEPTH)) begin
         s = s - (AW+1)'(QUEUE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   // Wrap the deadline once past the period
   assign new_dl = (sum_ff > {1'b0, period}) ? (sum_ff - {1'b0, period}) : sum_ff;

   assign rd_key     = sort_key(ram_rd_data.deadline, now_ff, period);
   assign more_items = ((CW+1)'(i_ff) + (CW+1)'(1)) < (CW+1)'(cnt_ff);
   assign head_next  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);

   // Next-state and datapath control
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      head_in     = head_ff;
      i_in        = i_ff;
      p_in        = p_ff;
      now_in      = now_ff;
      job_in      = job_ff;
      sum_in      = sum_ff;
      cur_in      = cur_ff;
      cur_key_in  = cur_key_ff;
      head_dl_in  = head_dl_ff;
      head_job_in = head_job_ff;
      status_in   = status_ff;
      fired_in    = fired_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = phys(head_ff, p_ff);
      ram_wr_data = cur_ff;
      ram_rd_addr = head_ff;
      res_valid   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in   = req.now_time;
               job_in   = req.job_id;
               fired_in = '0;
               if (req.cmd == CMD_SCHEDULE) begin
                  if (cnt_ff == CW'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     sum_in    = {1'b0, req.now_time} + {1'b0, req.delay_ticks};
                     status_in = ST_ACCEPTED;
                     state_in  = S_CALC;
                  end
               end else begin
                  if ((cnt_ff != '0) && (head_dl_ff == req.now_time)) begin
                     status_in = ST_FIRED;
                     fired_in  = head_job_ff;
                     head_in   = head_next;
                     cnt_in    = cnt_ff - CW'(1);
                     state_in  = S_HRD;
                  end else begin
                     status_in = ST_IDLE;
                     state_in  = S_RESP;
                  end
               end
            end
         end
         S_CALC: begin
            // Append the new entry at the tail, then re-sort
            ram_wr_en   = 1'b1;
            ram_wr_addr = phys(head_ff, cnt_ff[AW-1:0]);
            ram_wr_data = '{job: job_ff, deadline: new_dl[TIME_W-1:0]};
            cnt_in      = cnt_ff + CW'(1);
            i_in        = AW'(1);
            state_in    = (cnt_ff == '0) ? S_HRD : S_LOAD;
         end
         S_LOAD: begin
            ram_rd_addr = phys(head_ff, i_ff);
            state_in    = S_FETCH;
         end
         S_FETCH: begin
            cur_in      = ram_rd_data;
            cur_key_in  = rd_key;
            p_in        = i_ff;
            ram_rd_addr = phys(head_ff, i_ff - AW'(1));
            state_in    = S_CMP;
         end
         S_CMP: begin
            ram_wr_en = 1'b1;
            if (rd_key > cur_key_ff) begin
               // Shift the larger entry up one place and look further down
               ram_wr_data = ram_rd_data;
               p_in        = p_ff - AW'(1);
               if (p_ff > AW'(1)) begin
                  ram_rd_addr = phys(head_ff, p_ff - AW'(2));
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = more_items ? S_LOAD : S_HRD;
            end
         end
         S_PLACE: begin
            ram_wr_en = 1'b1;
            i_in      = i_ff + AW'(1);
            state_in  = more_items ? S_LOAD : S_HRD;
         end
         S_HRD: begin
            state_in = S_HLD;
         end
         S_HLD: begin
            head_dl_in  = ram_rd_data.deadline;
            head_job_in = ram_rd_data.job;
            state_in    = S_RESP;
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         head_ff  <= head_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      p_ff        <= p_in;
      now_ff      <= now_in;
      job_ff      <= job_in;
      sum_ff      <= sum_in;
      cur_ff      <= cur_in;
      cur_key_ff  <= cur_key_in;
      head_dl_ff  <= head_dl_in;
      head_job_ff <= head_job_in;
      status_ff   <= status_in;
      fired_ff    <= fired_in;
   end

   assign req_ready = (state_ff == S_IDLE);

   // Result built from the queue state after the transaction
   always_comb begin
      res.status         = status_ff;
      res.fired_id       = fired_ff;
      res.match_valid    = (cnt_ff != '0);
      res.match_deadline = (cnt_ff != '0) ? head_dl_ff : '0;
      res.pending_count  = COUNT_W'(cnt_ff);
   end

endmodule

// ===== hdl/deadline_ordered_timer_queue_core.sv =====
// Top level of the deadline-ordered timer queue: stream ports, period register, output stage.
//
// Request channel (req_*): one transaction per command. req_tuser selects schedule (0) or
// tick (1); req_tdata carries the current time, the delay and the job id. Every request
// yields exactly one response transaction on rsp_*: status in rsp_tuser, and fired job,
// head deadline for the timer match and pending count in rsp_tdata.
// csr_wr_en/csr_wr_data write the timer period; write it only while the queue is idle.
// Queue entries live in one RAM addressed relative to a head pointer, so a pop just
// advances the head. A schedule appends at the tail and then runs a stable insertion
// sort through the RAM, one read-compare-write per cycle.
// A firing tick reads the new head entry from the RAM before it responds. A schedule's sort
// time grows with the number of queued entries and of entries moved, with the RAM read/write
// port pair as the limit. One request is processed at a time.
// Reset empties the queue and sets the period to all ones; RAM contents need no clearing.
// When the receiver stalls, the response register holds; a new request is still taken
// and processed, and its response waits until the register frees.
module deadline_ordered_timer_queue_core
   import dotq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // now_time[31:0], delay_ticks[63:32], job_id[71:64]
   input  logic        req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // fired_id[7:0], match_valid[8], match_deadline[40:9],
                                    // pending_count[45:41], zero fill[47:46]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);

   logic [TIME_W-1:0] period_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   req_type   req;
   logic      res_valid;
   rsp_type   res;
   logic      res_take;
   logic      ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   entry_type ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [$bits(entry_type)-1:0] ram_rd_bits;
   entry_type ram_rd_data;

   // Unpack the request transaction
   assign req.cmd         = req_tuser;
   assign req.now_time    = req_tdata[31:0];
   assign req.delay_ticks = req_tdata[63:32];
   assign req.job_id      = req_tdata[71:64];

   // Hold the timer period
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '1;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   dotq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .period      (period_ff),
      .req_valid   (req_tvalid),
      .req         (req),
      .req_ready   (req_tready),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   dotq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = entry_type'(ram_rd_bits);

   // Load the response register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   // Pack the response transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {2'b00, rsp_data_ff.pending_count, rsp_data_ff.match_deadline,
                        rsp_data_ff.match_valid, rsp_data_ff.fired_id};

endmodule

// ===== verif/testbench.sv =====
// Self-checking stream testbench for the deadline-ordered timer queue core.
`timescale 1ns / 1ps

module testbench
   import dotq_pkg::*;
();

   localparam int DEPTH        = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 110;
   localparam int PHASE_COUNT  = 7;
   localparam int REPORT_LIMIT = 10;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // now_time[31:0], delay_ticks[63:32], job_id[71:64]
   logic        req_tuser;   // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // fired_id[7:0], match_valid[8], match_deadline[40:9],
                             // pending_count[45:41], zero fill[47:46]
   logic [1:0]  rsp_tuser;   // status[1:0]
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   // Shadow of the timer queue: period register and the ordered slots
   logic [TIME_W-1:0] shadow_period;
   logic [TIME_W-1:0] shadow_deadline [DEPTH];
   logic [JOB_W-1:0]  shadow_job [DEPTH];
   int                shadow_count;

   rsp_type due_responses [$];
   int      mismatch_count;
   int      cycle_count;
   bit      quiet_phase;
   bit      hold_off_request;
   int      hold_left;

   // Directed stimulus table
   req_type directed_req [$];
   rsp_type directed_rsp [$];
   bit      directed_known [$];

   deadline_ordered_timer_queue_core #(
      .QUEUE_DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("deadline_ordered_timer_queue_core: mismatch");
         $finish;
      end
   end

   // Ordering rank: deadlines already behind now count one period later
   function automatic logic [TIME_W:0] deadline_rank(input logic [TIME_W-1:0] deadline,
                                                     input logic [TIME_W-1:0] now);
      logic [TIME_W:0] rank;
      rank = {1'b0, deadline};
      if (deadline < now) begin
         rank = rank + {1'b0, shadow_period};
      end
      return rank;
   endfunction

   // Apply one command to the shadow queue and return the response it yields
   function automatic rsp_type run_queue_command(input req_type r);
      rsp_type           res;
      logic [TIME_W:0]   total;
      logic [TIME_W-1:0] d;
      logic [JOB_W-1:0]  j;
      logic [TIME_W:0]   k;
      int                i;
      int                p;
      res = '0;
      if (r.cmd == CMD_SCHEDULE) begin
         if (shadow_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            total = {1'b0, r.now_time} + {1'b0, r.delay_ticks};
            if (total > {1'b0, shadow_period}) begin
               total = total - {1'b0, shadow_period};
            end
            shadow_deadline[shadow_count] = total[TIME_W-1:0];
            shadow_job[shadow_count] = r.job_id;
            shadow_count++;
            // Stable insertion sort against the current time
            for (i = 1; i < shadow_count; i++) begin
               d = shadow_deadline[i];
               j = shadow_job[i];
               k = deadline_rank(d, r.now_time);
               p = i;
               while (p > 0 && deadline_rank(shadow_deadline[p-1], r.now_time) > k) begin
                  shadow_deadline[p] = shadow_deadline[p-1];
                  shadow_job[p] = shadow_job[p-1];
                  p--;
               end
               shadow_deadline[p] = d;
               shadow_job[p] = j;
            end
            res.status = ST_ACCEPTED;
         end
      end else if (shadow_count > 0 && shadow_deadline[0] == r.now_time) begin
         // Fire the head and shift the rest up
         res.fired_id = shadow_job[0];
         for (i = 0; i < DEPTH - 1; i++) begin
            shadow_deadline[i] = shadow_deadline[i+1];
            shadow_job[i] = shadow_job[i+1];
         end
         shadow_deadline[DEPTH-1] = '0;
         shadow_job[DEPTH-1] = '0;
         shadow_count--;
         res.status = ST_FIRED;
      end else begin
         res.status = ST_IDLE;
      end
      res.match_valid = (shadow_count > 0);
      res.match_deadline = (shadow_count > 0) ? shadow_deadline[0] : '0;
      res.pending_count = COUNT_W'(shadow_count);
      return res;
   endfunction

   task automatic log_mismatch(input string why, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $write("%s: want st=%0d id=%02h mv=%0b dl=%08h n=%0d, ",
                why, want.status, want.fired_id, want.match_valid, want.match_deadline,
                want.pending_count);
         $display("got st=%0d id=%02h mv=%0b dl=%08h n=%0d",
                  got.status, got.fired_id, got.match_valid, got.match_deadline,
                  got.pending_count);
      end
   endtask

   // Receiver: check each response transaction, stall at random or for a long hold-off
   initial begin
      rsp_type got;
      rsp_type want;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.fired_id = rsp_tdata[7:0];
            got.match_valid = rsp_tdata[8];
            got.match_deadline = rsp_tdata[40:9];
            got.pending_count = rsp_tdata[45:41];
            if (due_responses.size() == 0) begin
               log_mismatch("unexpected response", '0, got);
            end else begin
               want = due_responses.pop_front();
               if (got.status !== want.status || got.fired_id !== want.fired_id ||
                   got.match_valid !== want.match_valid ||
                   got.match_deadline !== want.match_deadline ||
                   got.pending_count !== want.pending_count) begin
                  log_mismatch("response differs", want, got);
               end
            end
         end
         if (hold_off_request) begin
            hold_left = HOLD_CYCLES;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (quiet_phase) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 30);
         end
      end
   end

   // Offer one request transaction, then record the response it must produce
   task automatic send_request(input req_type r, input bit known, input rsp_type typed);
      rsp_type predicted;
      while (!quiet_phase && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.job_id, r.delay_ticks, r.now_time};
      req_tuser <= r.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = run_queue_command(r);
      due_responses.push_back(known ? typed : predicted);
   endtask

   // Hold the sender until every response is in, then let the core settle
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (due_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_row(input logic cmd, input logic [31:0] now, input logic [31:0] delay,
                          input logic [7:0] job, input bit known, input logic [1:0] st,
                          input logic [7:0] fired, input logic mv, input logic [31:0] md,
                          input logic [4:0] cnt);
      req_type r;
      rsp_type e;
      r.cmd = cmd;
      r.now_time = now;
      r.delay_ticks = delay;
      r.job_id = job;
      e.status = st;
      e.fired_id = fired;
      e.match_valid = mv;
      e.match_deadline = md;
      e.pending_count = cnt;
      directed_req.push_back(r);
      directed_rsp.push_back(e);
      directed_known.push_back(known);
   endtask

   initial begin
      req_type     r;
      logic [31:0] sim_now;
      logic [31:0] new_period;
      int          phase;
      int          n;
      int          pick;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_SCHEDULE;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      mismatch_count = 0;
      quiet_phase = 0;
      hold_off_request = 0;
      hold_left = 0;
      shadow_period = 32'hFFFF_FFFF;
      shadow_count = 0;
      for (n = 0; n < DEPTH; n++) begin
         shadow_deadline[n] = '0;
         shadow_job[n] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty queue, extreme times and wrap of the deadline sum
      add_row(CMD_TICK, 32'd0, 32'd0, 8'h00, 1, ST_IDLE, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd0, 32'd0, 8'hFF, 1, ST_ACCEPTED, 8'h00, 1'b1, 32'd0, 5'd1);
      add_row(CMD_TICK, 32'd0, 32'd0, 8'h00, 1, ST_FIRED, 8'hFF, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1, ST_ACCEPTED, 8'h00,
              1'b1, 32'hFFFF_FFFF, 5'd1);
      add_row(CMD_TICK, 32'h1234_5678, 32'hFFFF_FFFF, 8'hFF, 1, ST_IDLE, 8'h00, 1'b1,
              32'hFFFF_FFFF, 5'd1);
      add_row(CMD_TICK, 32'hFFFF_FFFF, 32'd0, 8'h00, 1, ST_FIRED, 8'h00, 1'b0, 32'd0, 5'd0);
      // Fill to the brim: equal deadlines, a deadline behind now, a wrapped one equal to now
      add_row(CMD_SCHEDULE, 32'd1000, 32'd0, 8'h11, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd50, 8'h80, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd50, 8'h81, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd50, 8'h82, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd1, 8'h22, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'hFFFF_FF00, 8'h33, 0, ST_ACCEPTED, 8'h00, 1'b0,
              32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd3000, 8'h44, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd7, 8'h55, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd50, 8'h83, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'h7FFF_FFFF, 8'h66, 0, ST_ACCEPTED, 8'h00, 1'b0,
              32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd2, 8'h77, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd100, 8'h88, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'hFFFF_FFFF, 8'h99, 0, ST_ACCEPTED, 8'h00, 1'b0,
              32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd20, 8'hAA, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd9, 8'hBB, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd64, 8'hCC, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_SCHEDULE, 32'd1000, 32'd5, 8'hDD, 1, ST_FULL, 8'h00, 1'b1, 32'd1000, 5'd16);
      // Two jobs share the head deadline: both fire on the same time
      add_row(CMD_TICK, 32'd1000, 32'd0, 8'h00, 1, ST_FIRED, 8'h11, 1'b1, 32'd1000, 5'd15);
      add_row(CMD_TICK, 32'd1000, 32'd0, 8'h00, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);
      add_row(CMD_TICK, 32'd999, 32'd0, 8'h00, 0, ST_ACCEPTED, 8'h00, 1'b0, 32'd0, 5'd0);

      for (n = 0; n < directed_req.size(); n++) begin
         send_request(directed_req[n], directed_known[n], directed_rsp[n]);
      end

      // Random phases, each under its own timer period
      sim_now = 32'd1000;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: new_period = 32'd1000;
               2: new_period = 32'd1;
               3: new_period = 32'd0;
               4: new_period = 32'h8000_0000;
               5: new_period = $urandom_range(2, 65535);
               default: new_period = 32'hFFFF_FFFF;
            endcase
            drain_responses();
            csr_wr_en <= 1'b1;
            csr_wr_data <= new_period;
            @(posedge clock);
            csr_wr_en <= 1'b0;
            shadow_period = new_period;
         end
         quiet_phase = (phase == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 20) begin
               hold_off_request = 1;
            end
            if ($urandom_range(0, 99) < 4) begin
               sim_now = $urandom();
            end
            if (shadow_period != 32'd0 && shadow_period != 32'hFFFF_FFFF) begin
               sim_now = sim_now % shadow_period;
            end
            r.job_id = $urandom_range(0, 255);
            r.delay_ticks = $urandom();
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < ((shadow_count == DEPTH) ? 20 : 45)) begin
               // Schedule, mostly with short delays
               r.cmd = CMD_SCHEDULE;
               r.now_time = sim_now;
               if (pick < 65) begin
                  r.delay_ticks = $urandom_range(0, 80);
               end else if (pick < 80 && shadow_period != 32'd0) begin
                  r.delay_ticks = $urandom_range(0, shadow_period);
               end
               sim_now = sim_now + $urandom_range(0, 6);
            end else begin
               // Tick, mostly at the head deadline so that jobs fire
               r.cmd = CMD_TICK;
               if (shadow_count > 0 && pick < 65) begin
                  r.now_time = shadow_deadline[0];
                  sim_now = shadow_deadline[0];
               end else if (shadow_count > 1 && pick < 72) begin
                  r.now_time = shadow_deadline[shadow_count-1];
               end else if (pick < 85) begin
                  r.now_time = $urandom();
               end else begin
                  r.now_time = sim_now + $urandom_range(0, 3);
               end
            end
            send_request(r, 0, '0);
         end
      end
      quiet_phase = 0;

      drain_responses();
      repeat (20) @(posedge clock);
      mismatch_count += due_responses.size();
      if (mismatch_count == 0) begin
         $display("deadline_ordered_timer_queue_core: match");
      end else begin
         $display("deadline_ordered_timer_queue_core: mismatch");
      end
      $finish;
   end

endmodule
